>>> hw/rtl/sffr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI firmware flash read - shared definitions
// Item types, access codes, error codes and fixed constants.
// ----------------------------------------------------------------------------
package sffr_pkg;

   localparam int FLASH_ADDR_BITS_DEF = 18;

   localparam logic [7:0] CMD_READ   = 8'h03;
   localparam int         CTRL_EN    = 15;
   localparam int         CTRL_BUSY  = 7;
   localparam logic [2:0] ARG_LIMIT  = 3'd5;
   localparam logic [1:0] DEV_FLASH  = 2'd1;

   typedef enum logic [1:0] {
      OP_WR_CTRL = 2'd0,
      OP_WR_DATA = 2'd1,
      OP_RD_DATA = 2'd2,
      OP_LOAD    = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0,
      ERR_CMD  = 2'd1,
      ERR_DEV  = 2'd2
   } err_type;

   typedef struct packed {
      opcode_type  opcode;
      logic [15:0] write_value;
      logic [17:0] load_address;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [15:0] control_value;
      err_type     error_code;
   } rsp_item_type;

endpackage

>>> hw/rtl/sffr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI firmware flash read - single-port RAM
// One access per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module sffr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

>>> hw/rtl/spi_firmware_flash_read_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI firmware flash read - top level
// Bus-access front end of a serial controller with an attached flash that
// answers the standard read command.
// ----------------------------------------------------------------------------
// One item is one bus access: control write, data write, data read or flash
// load. Items are taken one per clock while req_stall is low, and each returns
// exactly one result item through the decode stage, then the output register.
// The rate fits the flash store, a single-port RAM that sees at most one
// access per item: a load writes it, a streaming data byte reads it. Control
// write takes bits 9:8 as device select; data writes act only while bit 15 is
// set, clear busy bit 7 and go to device 1 (the flash). Byte 0x03 opens the
// read stream, three address bytes follow, then each byte returns the next
// flash byte. The stream never closes. The flash store has no reset and no
// clearing pass, so it is usable right after reset; locations never loaded
// read back as whatever the RAM holds.
// ----------------------------------------------------------------------------
module spi_firmware_flash_read_top
   import sffr_pkg::*;
#(
   parameter int FLASH_ADDR_BITS = FLASH_ADDR_BITS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   localparam int FLASH_DEPTH = 1 << FLASH_ADDR_BITS;

   // decode stage contents; the byte may still come from the flash read
   typedef struct packed {
      logic [15:0] control;
      err_type     error;
      logic        byte_upd;   // access changes the output byte
      logic        byte_mem;   // new byte is the flash read data
      logic [7:0]  byte_val;
   } stage_type;

   // architectural state
   logic [15:0]                control_ff,   control_in;
   logic [1:0]                 device_ff,    device_in;
   logic                       read_mode_ff, read_mode_in;
   logic [2:0]                 arg_count_ff, arg_count_in;
   logic [FLASH_ADDR_BITS-1:0] addr_ff,      addr_in;
   logic [7:0]                 out_byte_ff,  out_byte_in;

   // pipeline
   logic         s1_valid_ff, s1_valid_in;
   stage_type    s1_ff, s1_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   logic       accept;
   logic       s1_move;
   logic [2:0] arg_next;
   logic [7:0] s1_byte;

   // flash port
   logic                       mem_we, mem_re;
   logic [FLASH_ADDR_BITS-1:0] mem_addr;
   logic [7:0]                 mem_rdata;

   // handshake: the output register parts the two sides, so an item is
   // taken whenever the decode stage is empty or moving on
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !s1_move;
   assign accept    = req_valid && !req_stall;

   assign arg_next = (arg_count_ff < ARG_LIMIT) ? arg_count_ff + 3'd1 : ARG_LIMIT;

   // access decode, state update and flash access
   always_comb begin
      control_in   = control_ff;
      device_in    = device_ff;
      read_mode_in = read_mode_ff;
      arg_count_in = arg_count_ff;
      addr_in      = addr_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = addr_ff;
      s1_in        = s1_ff;

      if (accept) begin
         s1_in.error    = ERR_NONE;
         s1_in.byte_upd = 1'b0;
         s1_in.byte_mem = 1'b0;
         s1_in.byte_val = req_item.write_value[7:0];

         unique case (req_item.opcode)
            OP_WR_CTRL: begin
               control_in = req_item.write_value;
               device_in  = req_item.write_value[9:8];
            end
            OP_WR_DATA: begin
               if (control_ff[CTRL_EN]) begin
                  control_in[CTRL_BUSY] = 1'b0;
                  if (device_ff != DEV_FLASH) begin
                     s1_in.error = ERR_DEV;
                  end else if (!read_mode_ff) begin
                     if (req_item.write_value[7:0] != CMD_READ) begin
                        s1_in.error = ERR_CMD;
                     end else begin
                        read_mode_in   = 1'b1;
                        arg_count_in   = arg_next;
                        s1_in.byte_upd = 1'b1;
                     end
                  end else begin
                     arg_count_in   = arg_next;
                     s1_in.byte_upd = 1'b1;
                     if (arg_next < ARG_LIMIT) begin
                        // address byte shifts in from the right
                        addr_in = {addr_ff[FLASH_ADDR_BITS-9:0],
                                   req_item.write_value[7:0]};
                     end else begin
                        mem_re         = 1'b1;
                        s1_in.byte_mem = 1'b1;
                        addr_in        = addr_ff + 1'b1;
                     end
                  end
               end
            end
            OP_RD_DATA: begin
            end
            OP_LOAD: begin
               mem_we   = 1'b1;
               mem_addr = FLASH_ADDR_BITS'(req_item.load_address);
            end
            default: begin
            end
         endcase

         s1_in.control = control_in;
      end
   end

   // stage control and output register
   assign s1_byte = !s1_ff.byte_upd ? out_byte_ff :
                    s1_ff.byte_mem  ? mem_rdata   : s1_ff.byte_val;

   always_comb begin
      s1_valid_in  = s1_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      out_byte_in  = out_byte_ff;
      rsp_item_in  = rsp_item_ff;

      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end

      if (s1_move) begin
         rsp_valid_in              = 1'b1;
         out_byte_in               = s1_byte;
         rsp_item_in.read_data     = s1_byte;
         rsp_item_in.control_value = s1_ff.control;
         rsp_item_in.error_code    = s1_ff.error;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff   <= '0;
         device_ff    <= '0;
         read_mode_ff <= 1'b0;
         arg_count_ff <= '0;
         addr_ff      <= '0;
         out_byte_ff  <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         control_ff   <= control_in;
         device_ff    <= device_in;
         read_mode_ff <= read_mode_in;
         arg_count_ff <= arg_count_in;
         addr_ff      <= addr_in;
         out_byte_ff  <= out_byte_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      rsp_item_ff <= rsp_item_in;
   end

   sffr_ram #(
      .WIDTH (8),
      .DEPTH (FLASH_DEPTH)
   ) u_flash (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (req_item.write_value[7:0]),
      .rdata (mem_rdata)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

>>> hw/rtl/sffr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SPI firmware flash read - port checker
// Watches the top-level ports for handshake and ordering slips.
// ----------------------------------------------------------------------------
module sffr_checker
   import sffr_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_item
);

   logic [1:0] inflight_ff, inflight_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      inflight_in = inflight_ff;
      if (req_take && !rsp_take) begin
         inflight_in = inflight_ff + 2'd1;
      end else if (!req_take && rsp_take) begin
         inflight_in = inflight_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   // no result without an item in flight
   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 2'd0)
      else $error("result item with nothing in flight");

   // two items in flight and output stalled: input must stall
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (inflight_ff == 2'd2) && rsp_stall |-> req_stall)
      else $error("item accepted with pipeline full");

   // any error comes from an enabled data write, which clears busy
   a_err_ctrl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.error_code != ERR_NONE) |->
         rsp_item.control_value[CTRL_EN] && !rsp_item.control_value[CTRL_BUSY])
      else $error("error reported without enabled data write");

endmodule

bind spi_firmware_flash_read_top sffr_checker u_sffr_checker (.*);
